// ----- rtl/core/rle_pair_run_encoder_unit_macros.svh -----
// Assertion macros used by the top level of the run length encoder.
`ifndef RLE_PAIR_RUN_ENCODER_UNIT_MACROS_SVH
`define RLE_PAIR_RUN_ENCODER_UNIT_MACROS_SVH

// Checked outside reset only.
`define RPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define RPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/core/rpe_pkg.sv -----
// Types, constants and helpers of the run length encoder.
`timescale 1ns / 1ps
package rpe_pkg;

  localparam int WINDOW_DEPTH = 256;
  localparam int MAX_RUN      = 66;
  localparam int MAX_PAIRS    = 65;
  localparam int MAX_LITERAL  = 63;
  localparam int LOOK_NEED    = (2 * MAX_PAIRS > MAX_RUN) ? 2 * MAX_PAIRS : MAX_RUN;

  localparam int WIN_AW = $clog2(WINDOW_DEPTH);
  localparam int WIN_CW = $clog2(WINDOW_DEPTH + 1);

  localparam int LIT_DEPTH = 64;
  localparam int LIT_W     = $clog2(LIT_DEPTH);

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [7:0] RUN_TAG  = 8'h40;
  localparam logic [7:0] PAIR_TAG = 8'h80;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic MODE_RAW = 1'b0;
  localparam logic MODE_RLE = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       end_of_payload;
  } req_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       burst_last;
    logic       payload_done;
  } res_t;

  typedef enum logic [2:0] {
    CMD_RAW,
    CMD_MARK,
    CMD_RUN,
    CMD_PAIR,
    CMD_FLUSH
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       b0;
    logic [7:0]       a;
    logic [7:0]       b;
    logic [LIT_W-1:0] n;
    logic             done;
  } cmd_t;

  typedef struct packed {
    logic             we;
    logic [LIT_W-1:0] addr;
    logic [7:0]       data;
  } lit_wr_t;

  // Circular window address: base plus offset, offset at most the depth.
  function automatic logic [WIN_AW-1:0] win_wrap(input logic [WIN_AW-1:0] base,
                                                 input logic [WIN_CW-1:0] off);
    logic [WIN_AW:0] s;
    s = {1'b0, base} + (WIN_AW + 1)'(off);
    if (s >= (WIN_AW + 1)'(WINDOW_DEPTH)) s = s - (WIN_AW + 1)'(WINDOW_DEPTH);
    return s[WIN_AW-1:0];
  endfunction

endpackage

// ----- rtl/core/rpe_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module rpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/rpe_front.sv -----
// Front end: takes items, keeps the lookahead window and decides tokens.
`timescale 1ns / 1ps
module rpe_front import rpe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  req_t    req_i,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i,
  output lit_wr_t lit_wr_o,
  output logic    cmd_push_o,
  output cmd_t    cmd_o,
  input  logic    cmd_full_i,
  input  logic    cmd_empty_i,
  input  logic    back_idle_i
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_DEC  = 3'd1;
  localparam logic [2:0] F_RD   = 3'd2;
  localparam logic [2:0] F_CMP  = 3'd3;
  localparam logic [2:0] F_CLS  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  localparam logic [2:0] PH_A   = 3'd0;
  localparam logic [2:0] PH_RUN = 3'd1;
  localparam logic [2:0] PH_B   = 3'd2;
  localparam logic [2:0] PH_P2  = 3'd3;
  localparam logic [2:0] PH_P3  = 3'd4;
  localparam logic [2:0] PH_PE  = 3'd5;
  localparam logic [2:0] PH_PO  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [2:0]        phase_q, phase_d;
  logic              mode_q, mode_d;
  logic [WIN_AW-1:0] head_q, head_d;
  logic [WIN_CW-1:0] cnt_q, cnt_d;
  logic              end_q, end_d;
  logic [LIT_W-1:0]  lit_q, lit_d;
  logic [WIN_CW-1:0] idx_q, idx_d;
  logic [WIN_CW-1:0] run_q, run_d;
  logic [WIN_CW-1:0] pairs_q, pairs_d;
  logic [7:0]        a_q, a_d;
  logic [7:0]        b_q, b_d;
  cmd_t              cmd_q, cmd_d;

  logic              win_we, win_re;
  logic [WIN_AW-1:0] win_waddr, win_raddr;
  logic [7:0]        win_rdata;

  logic              run_stop;
  logic [WIN_CW-1:0] run_nx, pairs_nx, pop_n;
  logic [LIT_W-1:0]  lit_nx;

  rpe_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_DEPTH)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (req_i.data_byte),
    .re_i    (win_re),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    mode_d     = mode_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    end_d      = end_q;
    lit_d      = lit_q;
    idx_d      = idx_q;
    run_d      = run_q;
    pairs_d    = pairs_q;
    a_d        = a_q;
    b_d        = b_q;
    cmd_d      = cmd_q;
    win_we     = 1'b0;
    win_re     = 1'b0;
    win_waddr  = win_wrap(head_q, cnt_q);
    win_raddr  = win_wrap(head_q, idx_q);
    lit_wr_o   = '{we: 1'b0, addr: lit_q, data: a_q};
    cmd_push_o = 1'b0;
    run_stop   = 1'b0;
    run_nx     = run_q + WIN_CW'(1);
    pairs_nx   = pairs_q + WIN_CW'(1);
    pop_n      = (run_q >= WIN_CW'(3)) ? run_q : (pairs_q << 1);
    lit_nx     = lit_q + LIT_W'(1);

    if (cfg_we_i) mode_d = cfg_wdata_i;

    unique case (state_q)
      F_IDLE: begin
        if (push) begin
          if (mode_q == MODE_RAW) begin
            if (req_i.op == OP_BYTE) begin
              cmd_d = '{kind: CMD_RAW, b0: req_i.data_byte, a: 8'd0, b: 8'd0,
                        n: '0, done: req_i.end_of_payload};
              state_d = F_PUSH;
            end
          end else begin
            if (req_i.op == OP_BYTE && !end_q && cnt_q < WIN_CW'(WINDOW_DEPTH)) begin
              win_we = 1'b1;
              cnt_d  = cnt_q + WIN_CW'(1);
              if (req_i.end_of_payload) end_d = 1'b1;
            end
            state_d = F_DEC;
          end
        end
      end
      F_DEC: begin
        if (!end_q && cnt_q < WIN_CW'(LOOK_NEED)) begin
          state_d = F_IDLE;
        end else if (cnt_q == '0) begin
          // end reached with an empty window: flush or give the bare marker
          cmd_d = '{kind: (lit_q != '0) ? CMD_FLUSH : CMD_MARK, b0: 8'(lit_q),
                    a: 8'd0, b: 8'd0, n: lit_q, done: 1'b1};
          lit_d   = '0;
          end_d   = 1'b0;
          state_d = F_PUSH;
        end else begin
          idx_d   = '0;
          run_d   = WIN_CW'(1);
          pairs_d = '0;
          phase_d = PH_A;
          state_d = F_RD;
        end
      end
      F_RD: begin
        win_re  = 1'b1;
        state_d = F_CMP;
      end
      F_CMP: begin
        state_d = F_CLS;
        unique case (phase_q)
          PH_A: begin
            a_d = win_rdata;
            if (cnt_q > WIN_CW'(1) && MAX_RUN > 1) begin
              idx_d   = WIN_CW'(1);
              phase_d = PH_RUN;
              state_d = F_RD;
            end else begin
              run_stop = 1'b1;
            end
          end
          PH_RUN: begin
            if (win_rdata == a_q) begin
              run_d = run_nx;
              if (run_nx < cnt_q && run_nx < WIN_CW'(MAX_RUN)) begin
                idx_d   = run_nx;
                state_d = F_RD;
              end else begin
                run_stop = 1'b1;
              end
            end else begin
              run_stop = 1'b1;
            end
          end
          PH_B: begin
            b_d     = win_rdata;
            idx_d   = WIN_CW'(2);
            phase_d = PH_P2;
            state_d = F_RD;
          end
          PH_P2: begin
            if (win_rdata == a_q) begin
              idx_d   = WIN_CW'(3);
              phase_d = PH_P3;
              state_d = F_RD;
            end
          end
          PH_P3: begin
            if (win_rdata == b_q) begin
              pairs_d = WIN_CW'(2);
              if (cnt_q > WIN_CW'(5) && MAX_PAIRS > 2) begin
                idx_d   = WIN_CW'(4);
                phase_d = PH_PE;
                state_d = F_RD;
              end
            end
          end
          PH_PE: begin
            if (win_rdata == a_q) begin
              idx_d   = idx_q + WIN_CW'(1);
              phase_d = PH_PO;
              state_d = F_RD;
            end
          end
          PH_PO: begin
            if (win_rdata == b_q) begin
              pairs_d = pairs_nx;
              if (((pairs_nx << 1) + WIN_CW'(1)) < cnt_q &&
                  pairs_nx < WIN_CW'(MAX_PAIRS)) begin
                idx_d   = pairs_nx << 1;
                phase_d = PH_PE;
                state_d = F_RD;
              end
            end
          end
          default: state_d = F_CLS;
        endcase
        // run scan over: try a pair run when the run is short
        if (run_stop) begin
          if (run_d < WIN_CW'(3) && cnt_q > WIN_CW'(5)) begin
            idx_d   = WIN_CW'(1);
            phase_d = PH_B;
            state_d = F_RD;
          end else begin
            state_d = F_CLS;
          end
        end
      end
      F_CLS: begin
        if (run_q >= WIN_CW'(3) || pairs_q >= WIN_CW'(3)) begin
          if (lit_q != '0) begin
            // pending literals go out first, the token waits for a later item
            cmd_d   = '{kind: CMD_FLUSH, b0: 8'(lit_q), a: 8'd0, b: 8'd0,
                        n: lit_q, done: 1'b0};
            lit_d   = '0;
            state_d = F_PUSH;
          end else begin
            head_d = win_wrap(head_q, pop_n);
            cnt_d  = cnt_q - pop_n;
            if (run_q >= WIN_CW'(3)) begin
              cmd_d = '{kind: CMD_RUN, b0: RUN_TAG | 8'(run_q - WIN_CW'(3)), a: a_q,
                        b: b_q, n: '0, done: 1'b0};
            end else begin
              cmd_d = '{kind: CMD_PAIR, b0: PAIR_TAG | 8'(pairs_q - WIN_CW'(2)), a: a_q,
                        b: b_q, n: '0, done: 1'b0};
            end
            if (end_q && cnt_q == pop_n) begin
              cmd_d.done = 1'b1;
              end_d      = 1'b0;
            end
            state_d = F_PUSH;
          end
        end else if (cmd_empty_i && back_idle_i) begin
          // hold the append until any earlier flush has read the store
          lit_wr_o.we = 1'b1;
          head_d      = win_wrap(head_q, WIN_CW'(1));
          cnt_d       = cnt_q - WIN_CW'(1);
          if (lit_nx >= LIT_W'(MAX_LITERAL)) begin
            cmd_d = '{kind: CMD_FLUSH, b0: 8'(lit_nx), a: 8'd0, b: 8'd0,
                      n: lit_nx, done: 1'b0};
            if (end_q && cnt_q == WIN_CW'(1)) begin
              cmd_d.done = 1'b1;
              end_d      = 1'b0;
            end
            lit_d   = '0;
            state_d = F_PUSH;
          end else begin
            lit_d   = lit_nx;
            state_d = F_IDLE;
          end
        end
      end
      F_PUSH: begin
        if (!cmd_full_i) begin
          cmd_push_o = 1'b1;
          state_d    = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign full  = (state_q != F_IDLE);
  assign cmd_o = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      phase_q <= PH_A;
      mode_q  <= MODE_RLE;
      head_q  <= '0;
      cnt_q   <= '0;
      end_q   <= 1'b0;
      lit_q   <= '0;
      run_q   <= '0;
      pairs_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      mode_q  <= mode_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      end_q   <= end_d;
      lit_q   <= lit_d;
      run_q   <= run_d;
      pairs_q <= pairs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    a_q   <= a_d;
    b_q   <= b_d;
    cmd_q <= cmd_d;
  end

endmodule

// ----- rtl/core/rpe_cmd_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module rpe_cmd_queue import rpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t               slot_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_q, rd_q;
  logic [CMDQ_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + CMDQ_AW'(1);
      if (do_pop) rd_q <= rd_q + CMDQ_AW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + (CMDQ_AW + 1)'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - (CMDQ_AW + 1)'(1);
    end
  end

endmodule

// ----- rtl/core/rpe_back.sv -----
// Back end: expands commands into result bytes and holds the output register.
`timescale 1ns / 1ps
module rpe_back import rpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_empty_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             lit_re_o,
  output logic [LIT_W-1:0] lit_raddr_o,
  input  logic [7:0]       lit_rdata_i,
  output logic             idle_o,
  output logic             empty,
  input  logic             pop,
  output res_t             res_o
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RD   = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [LIT_W-1:0] k_q, k_d;
  cmd_t             cur_q, cur_d;
  logic             vld_q, vld_d;
  res_t             res_q, res_d;
  logic             out_free, last;
  logic [7:0]       byte_sel;

  assign out_free = !vld_q || pop;

  always_comb begin
    unique case (cur_q.kind)
      CMD_RUN:   last = (k_q == LIT_W'(1));
      CMD_PAIR:  last = (k_q == LIT_W'(2));
      CMD_FLUSH: last = (k_q == cur_q.n);
      default:   last = (k_q == '0);
    endcase
    if (k_q == '0) begin
      byte_sel = cur_q.b0;
    end else begin
      unique case (cur_q.kind)
        CMD_FLUSH: byte_sel = lit_rdata_i;
        CMD_PAIR:  byte_sel = (k_q == LIT_W'(1)) ? cur_q.a : cur_q.b;
        default:   byte_sel = cur_q.a;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    cur_d       = cur_q;
    vld_d       = vld_q;
    res_d       = res_q;
    cmd_pop_o   = 1'b0;
    lit_re_o    = 1'b0;
    lit_raddr_o = k_q - LIT_W'(1);

    if (pop) vld_d = 1'b0;

    unique case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          k_d       = '0;
          state_d   = B_EMIT;
        end
      end
      B_RD: begin
        lit_re_o = 1'b1;
        state_d  = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          vld_d = 1'b1;
          res_d = '{has_byte: (cur_q.kind != CMD_MARK), out_byte: byte_sel,
                    burst_last: last, payload_done: last && cur_q.done};
          if (last) begin
            state_d = B_IDLE;
          end else begin
            k_d     = k_q + LIT_W'(1);
            state_d = (cur_q.kind == CMD_FLUSH) ? B_RD : B_EMIT;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign idle_o = (state_q == B_IDLE);
  assign empty  = !vld_q;
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    cur_q <= cur_d;
    res_q <= res_d;
  end

endmodule

// ----- rtl/core/rle_pair_run_encoder_unit.sv -----
// Top level of the run length encoder with pair runs.
`timescale 1ns / 1ps
`include "rle_pair_run_encoder_unit_macros.svh"
// Encodes a byte stream into run tokens (0x40|n-3, byte), pair tokens
// (0x80|pairs-2, two bytes) and literal blocks (count, bytes), or passes
// bytes through when the mode bit from cfg_wdata_i is 0. Items enter by
// push/full and results leave by empty/pop, at most one byte per result. An
// item holds full high while the front end works on it. With no decision the
// item passes through F_DEC, in pass-through through F_PUSH, before full
// drops. A decision reads the lookahead RAM one byte at a time on its single
// read port, each byte in F_RD then F_CMP: up to 66 bytes for a run scan, or
// up to 3 followed by up to 129 for a pair scan. It then classifies in F_CLS
// and queues the command in F_PUSH, which waits too while the command queue
// is full. A literal append also waits until the back end has read out any
// earlier literal flush. The back end fetches each command in B_IDLE, then
// gives one result per cycle for tokens while pop keeps the output free,
// and reads each literal byte in B_RD before it emits it. It runs on while
// the front end takes the next item. No clearing pass after reset.
module rle_pair_run_encoder_unit import rpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic empty,
  input  logic pop,
  output res_t res_o,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i
);

  lit_wr_t          lit_wr;
  logic             q_push, q_full, q_empty, q_pop;
  cmd_t             q_in, q_out;
  logic             back_idle;
  logic             lit_re;
  logic [LIT_W-1:0] lit_raddr;
  logic [7:0]       lit_rdata;

  rpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .lit_wr_o    (lit_wr),
    .cmd_push_o  (q_push),
    .cmd_o       (q_in),
    .cmd_full_i  (q_full),
    .cmd_empty_i (q_empty),
    .back_idle_i (back_idle)
  );

  rpe_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  rpe_ram #(
    .WIDTH(8),
    .DEPTH(LIT_DEPTH)
  ) u_lit_ram (
    .clk_i   (clk_i),
    .we_i    (lit_wr.we),
    .waddr_i (lit_wr.addr),
    .wdata_i (lit_wr.data),
    .re_i    (lit_re),
    .raddr_i (lit_raddr),
    .rdata_o (lit_rdata)
  );

  rpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .cmd_i       (q_out),
    .cmd_pop_o   (q_pop),
    .lit_re_o    (lit_re),
    .lit_raddr_o (lit_raddr),
    .lit_rdata_i (lit_rdata),
    .idle_o      (back_idle),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o)
  );

  `RPE_ASSERT(a_lit_write_safe, lit_wr.we |-> (back_idle && q_empty), "store written in flush")
  `RPE_ASSERT(a_cmd_no_overflow, q_push |-> !q_full, "command pushed into full queue")
  `RPE_ASSERT(a_cmd_no_underflow, q_pop |-> !q_empty, "command popped from empty queue")
  `RPE_ASSERT_ALWAYS(a_done_last, !empty && res_o.payload_done |-> res_o.burst_last, "early done")

endmodule
